@@ sv/gpio_timer_block_with_irq_core_defines.svh @@
// Shared assertion macros for the timer bank checkers.
// Both macros sample on clk_i and are off while rst_ni is low.
`ifndef GPIO_TIMER_BLOCK_WITH_IRQ_CORE_DEFINES_SVH
`define GPIO_TIMER_BLOCK_WITH_IRQ_CORE_DEFINES_SVH

// Same-cycle implication
`define GTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/gtb_pkg.sv @@
package gtb_pkg;

  // Beat field widths
  localparam int unsigned OPC_W    = 2;
  localparam int unsigned WOFS_W   = 6;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned LINES_W  = 5;
  localparam int unsigned CNT_W    = 33;
  localparam int unsigned STATUS_W = 21;

  // Status bit of timer 0; timer i uses TIMER_BIT0 + i
  localparam int unsigned TIMER_BIT0 = 16;
  // Low status bits that feed the gpio line
  localparam int unsigned GPIO_BITS  = 16;

  // Register word map
  localparam logic [WOFS_W-1:0] W_THRESH  = 6'd16;
  localparam logic [WOFS_W-1:0] W_CTRL    = 6'd32;
  localparam logic [WOFS_W-1:0] W_LIMIT   = 6'd37;
  localparam logic [WOFS_W-1:0] W_CURR    = 6'd42;
  localparam logic [WOFS_W-1:0] W_ENABLE  = 6'd47;
  localparam logic [WOFS_W-1:0] W_DISABLE = 6'd48;
  localparam logic [WOFS_W-1:0] W_STATUS  = 6'd52;

  // Control register bits
  localparam int unsigned TC_RUN        = 0;
  localparam int unsigned TC_SYMMETRIC  = 1;
  localparam int unsigned TC_IRQ_ENABLE = 3;

  typedef enum logic [OPC_W-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } gtb_op_e;

  // Command from the register decode to one timer
  typedef struct packed {
    logic              tick;
    logic              wr_ctrl;
    logic              wr_limit;
    logic              wr_count;
    logic [DATA_W-1:0] wdata;
  } gtb_tmr_cmd_t;

  // What one timer reports back
  typedef struct packed {
    logic              wrap;
    logic              irq_en_nxt;
    logic [DATA_W-1:0] ctrl;
    logic [DATA_W-1:0] limit;
    logic [DATA_W-1:0] cur;
  } gtb_tmr_stat_t;

endpackage

@@ sv/gtb_if.sv @@
// Input channel: one tick, register read or register write per beat
interface gtb_in_if import gtb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [WOFS_W-1:0] word_offset;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, opcode, word_offset, write_data, input ready);
  modport sink   (input valid, opcode, word_offset, write_data, output ready);
endinterface

// Result channel: one beat per input beat
interface gtb_out_if import gtb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic [LINES_W-1:0] timer_irq_lines;
  logic               gpio_irq_line;

  modport source (output valid, read_data, timer_irq_lines, gpio_irq_line, input ready);
  modport sink   (input valid, read_data, timer_irq_lines, gpio_irq_line, output ready);
endinterface

@@ sv/gtb_timer.sv @@
// One timer channel: control, limit and count registers, wrap detect and
// the current-count read view.
module gtb_timer import gtb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gtb_tmr_cmd_t  cmd_i,
  output gtb_tmr_stat_t stat_o
);

  logic [DATA_W-1:0] ctrl_q, ctrl_d;
  logic [DATA_W-1:0] limit_q, limit_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic [CNT_W-1:0]  period;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  lim_x2;
  logic [CNT_W-1:0]  mirror;
  logic              sym;
  logic              run;
  logic              wrap;

  assign sym    = ctrl_q[TC_SYMMETRIC];
  assign run    = ctrl_q[TC_RUN];
  assign lim_x2 = {limit_q, 1'b0};

  // Period: 2*limit when symmetric, limit+1 when sawtooth
  assign period  = sym ? lim_x2 : ({1'b0, limit_q} + CNT_W'(1));
  assign cnt_inc = count_q + CNT_W'(1);
  assign wrap    = cmd_i.tick && run &&
                   ((period == '0) || (cnt_inc >= period));

  // Register updates
  always_comb begin
    ctrl_d  = ctrl_q;
    limit_d = limit_q;
    count_d = count_q;
    if (cmd_i.wr_ctrl) begin
      ctrl_d = cmd_i.wdata;
    end
    if (cmd_i.wr_limit) begin
      limit_d = cmd_i.wdata;
    end
    if (cmd_i.wr_count) begin
      count_d = {1'b0, cmd_i.wdata};
    end else if (cmd_i.tick && run) begin
      count_d = wrap ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      limit_q <= '0;
      count_q <= '0;
    end else begin
      ctrl_q  <= ctrl_d;
      limit_q <= limit_d;
      count_q <= count_d;
    end
  end

  // Down-slope view of a symmetric timer
  assign mirror = lim_x2 - count_q;

  always_comb begin
    stat_o.wrap       = wrap;
    stat_o.irq_en_nxt = ctrl_d[TC_IRQ_ENABLE];
    stat_o.ctrl       = ctrl_q;
    stat_o.limit      = limit_q;
    if (sym && (count_q > {1'b0, limit_q}) && (count_q <= lim_x2)) begin
      stat_o.cur = mirror[DATA_W-1:0];
    end else begin
      stat_o.cur = count_q[DATA_W-1:0];
    end
  end

endmodule

@@ sv/gpio_timer_block_with_irq_core.sv @@
// Bank of NUM_TIMERS timers with a threshold store and an interrupt register
// file. Each input beat is a counter tick, a register read or a register
// write; every beat yields exactly one result beat carrying the read value
// (zero for ticks and writes) and the interrupt levels after the beat took
// effect. Throughput is one beat per clock while in_i.ready is high: the whole
// update is done in one pass into the state and the result register, and the
// result shows up in the cycle after acceptance. in_i.ready drops only while a
// result sits in the output register and out_o.ready is low.
module gpio_timer_block_with_irq_core import gtb_pkg::*; #(
  parameter int unsigned NUM_TIMERS     = 5,
  parameter int unsigned NUM_THRESHOLDS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gtb_in_if.sink    in_i,
  gtb_out_if.source out_o
);

  logic              acc;
  logic              is_tick;
  logic              is_read;
  logic              is_write;
  logic [WOFS_W-1:0] wofs;
  logic [DATA_W-1:0] wdata;

  logic [DATA_W-1:0]   thr_q [NUM_THRESHOLDS];
  logic [DATA_W-1:0]   en_q, en_d;
  logic [STATUS_W-1:0] st_q, st_d;

  gtb_tmr_cmd_t  tmr_cmd [NUM_TIMERS];
  gtb_tmr_stat_t tmr_st  [NUM_TIMERS];

  logic [DATA_W-1:0]  rd_d;
  logic [DATA_W-1:0]  pend;
  logic [LINES_W-1:0] lines_d;
  logic               gpio_d;

  logic               out_vld_q;
  logic [DATA_W-1:0]  rd_q;
  logic [LINES_W-1:0] lines_q;
  logic               gpio_q;

  // Handshake
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign wofs       = in_i.word_offset;
  assign wdata      = in_i.write_data;
  assign is_tick    = acc && (in_i.opcode == OP_TICK);
  assign is_read    = in_i.opcode == OP_READ;
  assign is_write   = acc && (in_i.opcode == OP_WRITE);

  // Timer channels
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_tmr
    always_comb begin
      tmr_cmd[i].tick     = is_tick;
      tmr_cmd[i].wr_ctrl  = is_write && (wofs == WOFS_W'(W_CTRL + i));
      tmr_cmd[i].wr_limit = is_write && (wofs == WOFS_W'(W_LIMIT + i));
      tmr_cmd[i].wr_count = is_write && (wofs == WOFS_W'(W_CURR + i));
      tmr_cmd[i].wdata    = wdata;
    end

    gtb_timer u_timer (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (tmr_cmd[i]),
      .stat_o (tmr_st[i])
    );
  end

  // Threshold store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_THRESHOLDS; k++) begin
        thr_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_THRESHOLDS; k++) begin
        if (is_write && (wofs == WOFS_W'(W_THRESH + k))) begin
          thr_q[k] <= wdata;
        end
      end
    end
  end

  // Enable mask and write-one-to-clear status; timer wraps set status bits
  always_comb begin
    en_d = en_q;
    st_d = st_q;
    if (is_write && (wofs == W_ENABLE)) begin
      en_d = en_q | wdata;
    end
    if (is_write && (wofs == W_DISABLE)) begin
      en_d = en_q & ~wdata;
    end
    if (is_write && (wofs == W_STATUS)) begin
      st_d = st_q & ~wdata[STATUS_W-1:0];
    end
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (tmr_st[i].wrap) begin
        st_d[TIMER_BIT0 + i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
      st_q <= '0;
    end else begin
      en_q <= en_d;
      st_q <= st_d;
    end
  end

  // Read mux, on the state before the beat
  always_comb begin
    rd_d = '0;
    if (is_read) begin
      for (int k = 0; k < NUM_THRESHOLDS; k++) begin
        if (wofs == WOFS_W'(W_THRESH + k)) begin
          rd_d = thr_q[k];
        end
      end
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (wofs == WOFS_W'(W_CTRL + i)) begin
          rd_d = tmr_st[i].ctrl;
        end
        if (wofs == WOFS_W'(W_LIMIT + i)) begin
          rd_d = tmr_st[i].limit;
        end
        if (wofs == WOFS_W'(W_CURR + i)) begin
          rd_d = tmr_st[i].cur;
        end
      end
      if ((wofs == W_ENABLE) || (wofs == W_DISABLE)) begin
        rd_d = en_q;
      end
      if (wofs == W_STATUS) begin
        rd_d = DATA_W'(st_q);
      end
    end
  end

  // Interrupt levels, on the state after the beat
  always_comb begin
    pend    = en_d & DATA_W'(st_d);
    lines_d = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      lines_d[i] = tmr_st[i].irq_en_nxt && pend[TIMER_BIT0 + i];
    end
    gpio_d = |pend[GPIO_BITS-1:0];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (acc) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q    <= rd_d;
      lines_q <= lines_d;
      gpio_q  <= gpio_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.read_data       = rd_q;
  assign out_o.timer_irq_lines = lines_q;
  assign out_o.gpio_irq_line   = gpio_q;

endmodule

@@ sv/gtb_checker.sv @@
`include "gpio_timer_block_with_irq_core_defines.svh"

// Port-level checks on the timer bank
module gtb_checker import gtb_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [OPC_W-1:0]   in_opcode_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [DATA_W-1:0]  out_read_data_i,
  input logic [LINES_W-1:0] out_lines_i,
  input logic               out_gpio_i
);

  // A pending result beat holds until taken
  `GTB_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_read_data_i) && $stable(out_lines_i) && $stable(out_gpio_i),
    "result beat dropped or changed while stalled")

  // Input back-pressure only while the result register is stuck
  `GTB_ASSERT_NOW(a_ready_stall, !in_ready_i, out_valid_i && !out_ready_i,
    "input stalled without a stalled result")

  // Every accepted beat produces a result beat in the next cycle
  `GTB_ASSERT_NEXT(a_acc_result, in_valid_i && in_ready_i, out_valid_i,
    "accepted beat gave no result")

  // Only register reads return data
  `GTB_ASSERT_NEXT(a_rd_zero, in_valid_i && in_ready_i && (in_opcode_i != OP_READ),
    out_read_data_i == '0, "non-read beat returned read data")

endmodule

bind gpio_timer_block_with_irq_core gtb_checker u_gtb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_opcode_i     (in_i.opcode),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_read_data_i (out_o.read_data),
  .out_lines_i     (out_o.timer_irq_lines),
  .out_gpio_i      (out_o.gpio_irq_line)
);
